### rtl/ech_pkg.sv
// ----------------------------------------------------------------------------
// ech_pkg
// Shared types and constants for the eval correction history block.
// ----------------------------------------------------------------------------
package ech_pkg;

    // table entries per side, must be a power of two
    localparam int TABLE_ENTRIES = 16384;
    // both scale factors are powers of two: divides become shifts
    localparam int GRAIN         = 256;
    localparam int WEIGHT_SCALE  = 1024;
    localparam int PIECE_KINDS   = 12;
    localparam int SQUARES       = 64;

    localparam int MAX_WEIGHT    = 16;
    localparam int SUM_DIVISOR   = 128;
    localparam int EVAL_BOUND    = 49000 - 99 - 1;

    localparam int TAW     = $clog2(TABLE_ENTRIES) + 1;   // side bit + slot
    localparam int SLOT_W  = TAW - 1;
    localparam int CNT_AW  = $clog2(PIECE_KINDS * SQUARES);
    localparam int WS_SH   = $clog2(WEIGHT_SCALE);
    localparam int ADJ_SH  = $clog2(SUM_DIVISOR) + $clog2(GRAIN);
    localparam int BW      = 48;                          // wide accumulate width

    localparam logic [2:0] CFG_ENTRY_LIMIT  = 3'd0;
    localparam logic [2:0] CFG_PAWN_GAIN    = 3'd1;
    localparam logic [2:0] CFG_MINOR_GAIN   = 3'd2;
    localparam logic [2:0] CFG_COUNTER_GAIN = 3'd3;
    localparam logic [2:0] CFG_NONPAWN_GAIN = 3'd4;

    localparam logic [2:0] MODE_ADJUST  = 3'd0;
    localparam logic [2:0] MODE_PAWN    = 3'd1;
    localparam logic [2:0] MODE_MINOR   = 3'd2;
    localparam logic [2:0] MODE_NONPAWN = 3'd3;
    localparam logic [2:0] MODE_COUNTER = 3'd4;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_SUM,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              load;     // capture input word
        logic              clr;      // clearing pass write
        logic [TAW-1:0]    clr_addr;
        logic              mul;      // register products
        logic              sum;      // register sums
        logic              fin;      // write back or load result
    } cmd_t;

    typedef struct packed {
        logic is_adjust;
        logic out_busy;
    } sts_t;

endpackage

### rtl/ech_ram.sv
// ----------------------------------------------------------------------------
// ech_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ech_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

### rtl/ech_ctrl.sv
// ----------------------------------------------------------------------------
// ech_ctrl
// Sequencer: clearing pass after reset, then read, multiply, sum, finish.
// ----------------------------------------------------------------------------
module ech_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  ech_pkg::sts_t sts,
    output ech_pkg::cmd_t cmd
);
    import ech_pkg::*;

    state_t         state_reg, state_next;
    logic [TAW-1:0] clr_reg, clr_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + 1'b1;
                if (&clr_reg) state_next = ST_IDLE;
            end
            ST_IDLE:  if (s_valid) state_next = ST_READ;
            ST_READ:  state_next = ST_MUL;
            ST_MUL:   state_next = ST_SUM;
            ST_SUM:   state_next = ST_DONE;
            ST_DONE:  if (!(sts.is_adjust && sts.out_busy)) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready      = (state_reg == ST_IDLE);
        cmd.load     = (state_reg == ST_IDLE) && s_valid;
        cmd.clr      = (state_reg == ST_CLEAR);
        cmd.clr_addr = clr_reg;
        cmd.mul      = (state_reg == ST_MUL);
        cmd.sum      = (state_reg == ST_SUM);
        cmd.fin      = (state_reg == ST_DONE) && !(sts.is_adjust && sts.out_busy);
    end
endmodule

### rtl/ech_dp.sv
// ----------------------------------------------------------------------------
// ech_dp
// Datapath: config registers, tables, blend and adjust arithmetic, result reg.
// ----------------------------------------------------------------------------
module ech_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [14:0]          cfg_data,
    input  logic [2:0]           s_mode,
    input  logic                 s_side,
    input  logic [63:0]          s_pawn_key,
    input  logic [63:0]          s_minor_key,
    input  logic [63:0]          s_white_nonpawn_key,
    input  logic [63:0]          s_black_nonpawn_key,
    input  logic [3:0]           s_prior_piece,
    input  logic [5:0]           s_prior_square,
    input  logic [7:0]           s_search_depth,
    input  logic signed [16:0]   s_eval_error,
    input  logic signed [16:0]   s_raw_eval,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [16:0]   m_corrected_eval,
    input  ech_pkg::cmd_t        cmd,
    output ech_pkg::sts_t        sts
);
    import ech_pkg::*;

    logic [14:0] limit_reg;
    logic [9:0]  pg_reg, mg_reg, cg_reg, ng_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= 15'd8192;
            pg_reg    <= 10'd128;
            mg_reg    <= 10'd128;
            cg_reg    <= 10'd128;
            ng_reg    <= 10'd128;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_ENTRY_LIMIT:  limit_reg <= cfg_data;
                CFG_PAWN_GAIN:    pg_reg    <= cfg_data[9:0];
                CFG_MINOR_GAIN:   mg_reg    <= cfg_data[9:0];
                CFG_COUNTER_GAIN: cg_reg    <= cfg_data[9:0];
                CFG_NONPAWN_GAIN: ng_reg    <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // captured input word
    logic [2:0]         mode_reg;
    logic [TAW-1:0]     pa_reg, ma_reg, wa_reg, ba_reg;
    logic [CNT_AW-1:0]  ca_reg;
    logic               cok_reg;
    logic [4:0]         w_reg;
    logic signed [16:0] err_reg, raw_reg;
    logic               cok;

    assign cok = (32'(s_prior_piece) < PIECE_KINDS) && (32'(s_prior_square) < SQUARES);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg <= s_mode;
            pa_reg   <= {s_side, s_pawn_key[SLOT_W-1:0]};
            ma_reg   <= {s_side, s_minor_key[SLOT_W-1:0]};
            wa_reg   <= {s_side, s_white_nonpawn_key[SLOT_W-1:0]};
            ba_reg   <= {s_side, s_black_nonpawn_key[SLOT_W-1:0]};
            ca_reg   <= cok ? CNT_AW'(32'(s_prior_piece) * SQUARES + 32'(s_prior_square))
                            : '0;
            cok_reg  <= cok;
            w_reg    <= (s_search_depth >= 8'(MAX_WEIGHT - 1)) ? 5'(MAX_WEIGHT)
                                                                : 5'(s_search_depth + 8'd1);
            err_reg  <= s_eval_error;
            raw_reg  <= s_raw_eval;
        end
    end

    // tables
    logic [15:0]       p_rd, m_rd, w_rd, b_rd, c_rd;
    logic [15:0]       new_a, new_b;
    logic              we_p, we_m, we_w, we_b, we_c;
    logic [TAW-1:0]    wa_p, wa_m, wa_w, wa_b;
    logic [CNT_AW-1:0] wa_c;

    always_comb begin
        we_p = cmd.clr || (cmd.fin && mode_reg == MODE_PAWN);
        we_m = cmd.clr || (cmd.fin && mode_reg == MODE_MINOR);
        we_w = cmd.clr || (cmd.fin && mode_reg == MODE_NONPAWN);
        we_b = we_w;
        we_c = cmd.clr || (cmd.fin && mode_reg == MODE_COUNTER && cok_reg);
        wa_p = cmd.clr ? cmd.clr_addr : pa_reg;
        wa_m = cmd.clr ? cmd.clr_addr : ma_reg;
        wa_w = cmd.clr ? cmd.clr_addr : wa_reg;
        wa_b = cmd.clr ? cmd.clr_addr : ba_reg;
        wa_c = cmd.clr ? cmd.clr_addr[CNT_AW-1:0] : ca_reg;
    end

    ech_ram #(.WIDTH(16), .DEPTH(2 * TABLE_ENTRIES)) u_pawn (
        .aclk, .we(we_p), .waddr(wa_p), .wdata(cmd.clr ? 16'd0 : new_a),
        .raddr(pa_reg), .rdata(p_rd));
    ech_ram #(.WIDTH(16), .DEPTH(2 * TABLE_ENTRIES)) u_minor (
        .aclk, .we(we_m), .waddr(wa_m), .wdata(cmd.clr ? 16'd0 : new_a),
        .raddr(ma_reg), .rdata(m_rd));
    ech_ram #(.WIDTH(16), .DEPTH(2 * TABLE_ENTRIES)) u_npw (
        .aclk, .we(we_w), .waddr(wa_w), .wdata(cmd.clr ? 16'd0 : new_a),
        .raddr(wa_reg), .rdata(w_rd));
    ech_ram #(.WIDTH(16), .DEPTH(2 * TABLE_ENTRIES)) u_npb (
        .aclk, .we(we_b), .waddr(wa_b), .wdata(cmd.clr ? 16'd0 : new_b),
        .raddr(ba_reg), .rdata(b_rd));
    ech_ram #(.WIDTH(16), .DEPTH(2 ** CNT_AW)) u_cnt (
        .aclk, .we(we_c), .waddr(wa_c), .wdata(cmd.clr ? 16'd0 : new_a),
        .raddr(ca_reg), .rdata(c_rd));

    // multiply stage
    logic signed [15:0]   old_a, cval;
    logic signed [BW-1:0] pa_mul_reg, pb_mul_reg, pe_mul_reg;
    logic signed [BW-1:0] ap_reg, am_reg, ac_reg, an_reg;

    always_comb begin
        cval = cok_reg ? $signed(c_rd) : 16'sd0;
        case (mode_reg)
            MODE_PAWN:    old_a = $signed(p_rd);
            MODE_MINOR:   old_a = $signed(m_rd);
            MODE_COUNTER: old_a = cval;
            default:      old_a = $signed(w_rd);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            pa_mul_reg <= BW'(old_a) * BW'($signed({1'b0, 14'(WEIGHT_SCALE) - 14'(w_reg)}));
            pb_mul_reg <= BW'($signed(b_rd)) *
                          BW'($signed({1'b0, 14'(WEIGHT_SCALE) - 14'(w_reg)}));
            pe_mul_reg <= BW'(err_reg) * BW'($signed({1'b0, w_reg}));
            ap_reg     <= BW'($signed(p_rd)) * BW'($signed({1'b0, pg_reg}));
            am_reg     <= BW'($signed(m_rd)) * BW'($signed({1'b0, mg_reg}));
            ac_reg     <= BW'(cval) * BW'($signed({1'b0, cg_reg}));
            an_reg     <= (BW'($signed(w_rd)) + BW'($signed(b_rd))) *
                          BW'($signed({1'b0, ng_reg}));
        end
    end

    // sum stage
    logic signed [BW-1:0] ba_sum_reg, bb_sum_reg, adj_sum_reg, eg;

    assign eg = pe_mul_reg * BW'(GRAIN);

    always_ff @(posedge aclk) begin
        if (cmd.sum) begin
            ba_sum_reg  <= pa_mul_reg + eg;
            bb_sum_reg  <= pb_mul_reg + eg;
            adj_sum_reg <= ap_reg + am_reg + ac_reg + an_reg;
        end
    end

    // finish: truncating divides by shift, clamps
    logic signed [BW-1:0] qa, qb, qadj, tot, lim;

    always_comb begin
        lim  = BW'($signed({1'b0, limit_reg}));
        qa   = (ba_sum_reg + (ba_sum_reg[BW-1] ? BW'((1 << WS_SH) - 1) : BW'(0))) >>> WS_SH;
        qb   = (bb_sum_reg + (bb_sum_reg[BW-1] ? BW'((1 << WS_SH) - 1) : BW'(0))) >>> WS_SH;
        qadj = (adj_sum_reg + (adj_sum_reg[BW-1] ? BW'((1 << ADJ_SH) - 1) : BW'(0)))
               >>> ADJ_SH;
        if (qa > lim) qa = lim;
        if (qa < -lim) qa = -lim;
        if (qb > lim) qb = lim;
        if (qb < -lim) qb = -lim;
        new_a = qa[15:0];
        new_b = qb[15:0];
        tot   = qadj + BW'(raw_reg);
        if (tot > BW'(EVAL_BOUND)) tot = BW'(EVAL_BOUND);
        if (tot < -BW'(EVAL_BOUND)) tot = -BW'(EVAL_BOUND);
    end

    // result register
    logic               ov_reg;
    logic signed [16:0] res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (cmd.fin && mode_reg == MODE_ADJUST) begin
            ov_reg <= 1'b1;
        end else if (m_ready) begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fin && mode_reg == MODE_ADJUST) begin
            res_reg <= tot[16:0];
        end
    end

    assign m_valid          = ov_reg;
    assign m_corrected_eval = res_reg;
    assign sts.is_adjust    = (mode_reg == MODE_ADJUST);
    assign sts.out_busy     = ov_reg && !m_ready;
endmodule

### rtl/eval_correction_history.sv
// ----------------------------------------------------------------------------
// eval_correction_history
// Correction tables with depth-weighted update and weighted eval adjustment.
//
//  channel | ports          | role
//  --------+----------------+-------------------------------
//  input   | s_valid/s_ready| one word: update or adjust
//  result  | m_valid/m_ready| corrected eval, adjust only
//  config  | cfg_we         | register write, no wait
//
// Each word passes through accept, table read, multiply, sum and finish,
// set by the registered table read and the multiply/sum stages.
// After reset a clearing pass zeroes all tables, walking 2*TABLE_ENTRIES
// addresses (32768) with s_ready low meanwhile. A waiting result only
// stalls a following adjust word in its finish step.
// ----------------------------------------------------------------------------
module eval_correction_history (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [14:0]         cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_mode,
    input  logic                s_side,
    input  logic [63:0]         s_pawn_key,
    input  logic [63:0]         s_minor_key,
    input  logic [63:0]         s_white_nonpawn_key,
    input  logic [63:0]         s_black_nonpawn_key,
    input  logic [3:0]          s_prior_piece,
    input  logic [5:0]          s_prior_square,
    input  logic [7:0]          s_search_depth,
    input  logic signed [16:0]  s_eval_error,
    input  logic signed [16:0]  s_raw_eval,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [16:0]  m_corrected_eval
);
    import ech_pkg::*;

    cmd_t cmd;
    sts_t sts;

    ech_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .sts, .cmd
    );

    ech_dp u_dp (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_data,
        .s_mode, .s_side, .s_pawn_key, .s_minor_key,
        .s_white_nonpawn_key, .s_black_nonpawn_key,
        .s_prior_piece, .s_prior_square, .s_search_depth,
        .s_eval_error, .s_raw_eval,
        .m_valid, .m_ready, .m_corrected_eval, .cmd, .sts
    );
endmodule

### rtl/ech_checker.sv
// ----------------------------------------------------------------------------
// ech_checker
// Port-level checks for eval_correction_history, bound to the top level.
// ----------------------------------------------------------------------------
module ech_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic signed [16:0]  m_corrected_eval
);
    // reset starts the clearing pass: nothing taken, nothing shown
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid) else $error("busy after reset");

    // one word at a time
    a_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready) else $error("ready after accept");

    // a result never appears in the cycle right after an accept
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid) else $error("early result");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_corrected_eval))
        else $error("result word dropped");
endmodule

bind eval_correction_history ech_checker u_ech_checker (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .m_corrected_eval
);
